/* rtl/lwcr_pkg.sv */
// shared constants and types of the loop timing worst-case recorder
package lwcr_pkg;

  localparam int FIELD_W         = 32;  // width of the cycle fields on the ports
  localparam int CNT_W           = 32;  // width of the saturating counters
  localparam int FLAG_W          = 2;   // width of the trace flag fields
  localparam int CYCLE_WIDTH_DEF = 32;  // default internal cycle width

  // validation result handed from the checker to the statistics unit
  typedef struct packed {
    logic              ok;     // sample passed validation
    logic [FLAG_W-1:0] flags;  // bit0 enabled, bit1 sampled
  } lwcr_chk_t;

endpackage

/* rtl/lwcr_check.sv */
// sample validation: flag ranges and segment sum identity
module lwcr_check #(
  parameter int CYCLE_WIDTH = lwcr_pkg::CYCLE_WIDTH_DEF
) (
  input  logic [lwcr_pkg::FLAG_W-1:0] trace_on,
  input  logic [lwcr_pkg::FLAG_W-1:0] trace_taken,
  input  logic [CYCLE_WIDTH-1:0]      pre,
  input  logic [CYCLE_WIDTH-1:0]      ctrl,
  input  logic [CYCLE_WIDTH-1:0]      post,
  input  logic [CYCLE_WIDTH-1:0]      total,
  output lwcr_pkg::lwcr_chk_t         chk
);

  localparam int SUM_W = CYCLE_WIDTH + 2;

  logic [SUM_W-1:0] seg_sum;
  logic             flags_ok;

  // exact sum, two guard bits so no wrap can fake a match
  assign seg_sum  = SUM_W'(pre) + SUM_W'(ctrl) + SUM_W'(post);
  assign flags_ok = (trace_on <= lwcr_pkg::FLAG_W'(1)) && (trace_taken <= trace_on);

  assign chk.ok    = flags_ok && (seg_sum == SUM_W'(total));
  assign chk.flags = {trace_taken[0], trace_on[0]};

endmodule

/* rtl/lwcr_stats.sv */
// running statistics: counters, segment peaks and the worst-case tick
module lwcr_stats #(
  parameter int CYCLE_WIDTH = lwcr_pkg::CYCLE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        upd,
  input  lwcr_pkg::lwcr_chk_t         chk,
  input  logic [CYCLE_WIDTH-1:0]      pre,
  input  logic [CYCLE_WIDTH-1:0]      ctrl,
  input  logic [CYCLE_WIDTH-1:0]      post,
  input  logic [CYCLE_WIDTH-1:0]      total,
  output logic                        replaced,
  output logic                        accepted,
  output logic [lwcr_pkg::CNT_W-1:0]  good_count,
  output logic [lwcr_pkg::CNT_W-1:0]  bad_count,
  output logic [CYCLE_WIDTH-1:0]      pre_max,
  output logic [CYCLE_WIDTH-1:0]      ctrl_max,
  output logic [CYCLE_WIDTH-1:0]      post_max,
  output logic [CYCLE_WIDTH-1:0]      wc_total,
  output logic [CYCLE_WIDTH-1:0]      wc_pre,
  output logic [CYCLE_WIDTH-1:0]      wc_ctrl,
  output logic [CYCLE_WIDTH-1:0]      wc_post,
  output logic [lwcr_pkg::FLAG_W-1:0] wc_flags
);

  logic replaced_next;

  assign replaced_next = chk.ok && ((good_count == '0) || (total > wc_total));

  // per-sample flags of the last transfer, plain payload
  always_ff @(posedge clk) begin
    if (upd) begin
      replaced <= replaced_next;
      accepted <= chk.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      good_count <= '0;
      bad_count  <= '0;
      pre_max    <= '0;
      ctrl_max   <= '0;
      post_max   <= '0;
      wc_total   <= '0;
      wc_pre     <= '0;
      wc_ctrl    <= '0;
      wc_post    <= '0;
      wc_flags   <= '0;
    end else if (upd) begin
      if (!chk.ok) begin
        if (bad_count != '1) bad_count <= bad_count + lwcr_pkg::CNT_W'(1);
      end else begin
        if (good_count != '1) good_count <= good_count + lwcr_pkg::CNT_W'(1);
        if (pre > pre_max) pre_max <= pre;
        if (ctrl > ctrl_max) ctrl_max <= ctrl;
        if (post > post_max) post_max <= post;
        if (replaced_next) begin
          wc_total <= total;
          wc_pre   <= pre;
          wc_ctrl  <= ctrl;
          wc_post  <= post;
          wc_flags <= chk.flags;
        end
      end
    end
  end

endmodule

/* rtl/loop_timing_worst_case_recorder.sv */
// top level of the loop timing worst-case recorder
//
// usage
//   input channel: one timing sample per transfer (in_valid / in_ready) with
//   the trace flags and the pre, control, post and total cycle counts
//   output channel: one result per sample (out_valid / out_ready) with the
//   accept and replace flags, both counters, the three segment peaks and the
//   stored worst-case tick, all as they stand after that sample
//   path: a sample is registered in the input register at its input transfer,
//   then enters the output stage with its result, which raises out_valid
//   throughput: one sample per cycle while the receiver does not stall; the rate
//   is set by the single register-to-register pass of validation and statistics update
//   stall: when the receiver holds out_ready low the result is held, one more
//   sample waits in the input register, and in_ready then drops
//   reset: rst (synchronous) empties both stages and clears every counter,
//   peak and the worst-case record
//   cycle values are kept at CYCLE_WIDTH bits inside; port fields are 32 bits
module loop_timing_worst_case_recorder #(
  parameter int CYCLE_WIDTH = lwcr_pkg::CYCLE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // sample channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lwcr_pkg::FLAG_W-1:0]  trace_on,
  input  logic [lwcr_pkg::FLAG_W-1:0]  trace_taken,
  input  logic [lwcr_pkg::FIELD_W-1:0] pre_cycles,
  input  logic [lwcr_pkg::FIELD_W-1:0] ctrl_cycles,
  input  logic [lwcr_pkg::FIELD_W-1:0] post_cycles,
  input  logic [lwcr_pkg::FIELD_W-1:0] tick_cycles,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         worst_replaced,
  output logic                         accepted,
  output logic [lwcr_pkg::CNT_W-1:0]   valid_count,
  output logic [lwcr_pkg::CNT_W-1:0]   reject_count,
  output logic [lwcr_pkg::FIELD_W-1:0] pre_peak,
  output logic [lwcr_pkg::FIELD_W-1:0] ctrl_peak,
  output logic [lwcr_pkg::FIELD_W-1:0] post_peak,
  output logic [lwcr_pkg::FIELD_W-1:0] worst_total,
  output logic [lwcr_pkg::FIELD_W-1:0] worst_pre,
  output logic [lwcr_pkg::FIELD_W-1:0] worst_ctrl,
  output logic [lwcr_pkg::FIELD_W-1:0] worst_post,
  output logic [lwcr_pkg::FLAG_W-1:0]  worst_flags
);

  // bits that survive between port width and internal width
  localparam int KEEP_W = (CYCLE_WIDTH < lwcr_pkg::FIELD_W) ? CYCLE_WIDTH
                                                           : lwcr_pkg::FIELD_W;

  // input register
  logic                        s1_valid;
  logic [lwcr_pkg::FLAG_W-1:0] s1_on;
  logic [lwcr_pkg::FLAG_W-1:0] s1_taken;
  logic [CYCLE_WIDTH-1:0]      s1_pre;
  logic [CYCLE_WIDTH-1:0]      s1_ctrl;
  logic [CYCLE_WIDTH-1:0]      s1_post;
  logic [CYCLE_WIDTH-1:0]      s1_total;

  logic                        advance;  // output stage can take a new result
  logic                        upd;      // sample moves from input to output stage
  lwcr_pkg::lwcr_chk_t         chk;

  // internal-width statistics
  logic [CYCLE_WIDTH-1:0]      pre_max;
  logic [CYCLE_WIDTH-1:0]      ctrl_max;
  logic [CYCLE_WIDTH-1:0]      post_max;
  logic [CYCLE_WIDTH-1:0]      wc_total;
  logic [CYCLE_WIDTH-1:0]      wc_pre;
  logic [CYCLE_WIDTH-1:0]      wc_ctrl;
  logic [CYCLE_WIDTH-1:0]      wc_post;

  assign advance  = !out_valid || out_ready;
  assign upd      = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  // input stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // input payload, truncated or zero extended to the internal width
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_on    <= trace_on;
      s1_taken <= trace_taken;
      s1_pre   <= CYCLE_WIDTH'(pre_cycles[KEEP_W-1:0]);
      s1_ctrl  <= CYCLE_WIDTH'(ctrl_cycles[KEEP_W-1:0]);
      s1_post  <= CYCLE_WIDTH'(post_cycles[KEEP_W-1:0]);
      s1_total <= CYCLE_WIDTH'(tick_cycles[KEEP_W-1:0]);
    end
  end

  // output stage occupancy; the payload lives in the statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  lwcr_check #(
    .CYCLE_WIDTH (CYCLE_WIDTH)
  ) u_check (
    .trace_on    (s1_on),
    .trace_taken (s1_taken),
    .pre         (s1_pre),
    .ctrl        (s1_ctrl),
    .post        (s1_post),
    .total       (s1_total),
    .chk         (chk)
  );

  // statistics change only when a result enters the output stage, so the
  // registers always hold the values of the result on display
  lwcr_stats #(
    .CYCLE_WIDTH (CYCLE_WIDTH)
  ) u_stats (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .chk        (chk),
    .pre        (s1_pre),
    .ctrl       (s1_ctrl),
    .post       (s1_post),
    .total      (s1_total),
    .replaced   (worst_replaced),
    .accepted   (accepted),
    .good_count (valid_count),
    .bad_count  (reject_count),
    .pre_max    (pre_max),
    .ctrl_max   (ctrl_max),
    .post_max   (post_max),
    .wc_total   (wc_total),
    .wc_pre     (wc_pre),
    .wc_ctrl    (wc_ctrl),
    .wc_post    (wc_post),
    .wc_flags   (worst_flags)
  );

  // cycle outputs: low bits of the internal value, zero extended
  assign pre_peak    = lwcr_pkg::FIELD_W'(pre_max[KEEP_W-1:0]);
  assign ctrl_peak   = lwcr_pkg::FIELD_W'(ctrl_max[KEEP_W-1:0]);
  assign post_peak   = lwcr_pkg::FIELD_W'(post_max[KEEP_W-1:0]);
  assign worst_total = lwcr_pkg::FIELD_W'(wc_total[KEEP_W-1:0]);
  assign worst_pre   = lwcr_pkg::FIELD_W'(wc_pre[KEEP_W-1:0]);
  assign worst_ctrl  = lwcr_pkg::FIELD_W'(wc_ctrl[KEEP_W-1:0]);
  assign worst_post  = lwcr_pkg::FIELD_W'(wc_post[KEEP_W-1:0]);

  // a rejected sample never becomes the worst case
  a_replace_needs_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(worst_replaced && !accepted))
    else $error("worst case replaced by a rejected sample");

  // the valid sample count never goes backwards
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (valid_count >= $past(valid_count)))
    else $error("valid count decreased");

  // a stalled output stage keeps the waiting sample in the input register
  a_hold_waiting: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("waiting sample lost while output stalled");

  // the stored worst tick is one of the valid samples, so it stays under the peaks
  a_peak_covers_worst: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pre_max >= wc_pre && ctrl_max >= wc_ctrl && post_max >= wc_post))
    else $error("segment peak below worst-case segment");

endmodule

/* test/loop_timing_worst_case_recorder_tb.sv */
// self-checking testbench of the loop timing worst-case recorder
`timescale 1ns / 1ps

module loop_timing_worst_case_recorder_tb;

  localparam int FIELD_W = lwcr_pkg::FIELD_W;
  localparam int FLAG_W  = lwcr_pkg::FLAG_W;
  localparam int CNT_W   = lwcr_pkg::CNT_W;

  // run limit, with room for the slowest correct run (long gaps on both sides)
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1330;
  localparam int BLOCK_ITEMS  = 150;   // random items per block of the random part
  localparam int TAIL_CYCLES  = 8;     // quiet cycles after the last result

  localparam logic [FIELD_W-1:0] ALL_ONES = '1;

  // one timing sample as it crosses the input channel
  typedef struct packed {
    logic [FLAG_W-1:0]  on;
    logic [FLAG_W-1:0]  taken;
    logic [FIELD_W-1:0] pre;
    logic [FIELD_W-1:0] ctrl;
    logic [FIELD_W-1:0] post;
    logic [FIELD_W-1:0] total;
  } tick_sample_t;

  // statistics reported after one sample
  typedef struct packed {
    logic               replaced;
    logic               acc;
    logic [CNT_W-1:0]   good_cnt;
    logic [CNT_W-1:0]   bad_cnt;
    logic [FIELD_W-1:0] pre_pk;
    logic [FIELD_W-1:0] ctrl_pk;
    logic [FIELD_W-1:0] post_pk;
    logic [FIELD_W-1:0] w_total;
    logic [FIELD_W-1:0] w_pre;
    logic [FIELD_W-1:0] w_ctrl;
    logic [FIELD_W-1:0] w_post;
    logic [FLAG_W-1:0]  w_flags;
  } tick_stats_t;

  // a row of the directed table; typed-in stats only where obvious
  typedef struct {
    tick_sample_t s;
    bit           has_stats;
    tick_stats_t  stats;
  } stim_row_t;

  logic clk;
  logic rst;

  logic               in_valid;
  logic               in_ready;
  logic [FLAG_W-1:0]  trace_on;
  logic [FLAG_W-1:0]  trace_taken;
  logic [FIELD_W-1:0] pre_cycles;
  logic [FIELD_W-1:0] ctrl_cycles;
  logic [FIELD_W-1:0] post_cycles;
  logic [FIELD_W-1:0] tick_cycles;

  logic               out_valid;
  logic               out_ready;
  logic               worst_replaced;
  logic               accepted;
  logic [CNT_W-1:0]   valid_count;
  logic [CNT_W-1:0]   reject_count;
  logic [FIELD_W-1:0] pre_peak;
  logic [FIELD_W-1:0] ctrl_peak;
  logic [FIELD_W-1:0] post_peak;
  logic [FIELD_W-1:0] worst_total;
  logic [FIELD_W-1:0] worst_pre;
  logic [FIELD_W-1:0] worst_ctrl;
  logic [FIELD_W-1:0] worst_post;
  logic [FLAG_W-1:0]  worst_flags;

  loop_timing_worst_case_recorder DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .trace_on       (trace_on),
    .trace_taken    (trace_taken),
    .pre_cycles     (pre_cycles),
    .ctrl_cycles    (ctrl_cycles),
    .post_cycles    (post_cycles),
    .tick_cycles    (tick_cycles),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .worst_replaced (worst_replaced),
    .accepted       (accepted),
    .valid_count    (valid_count),
    .reject_count   (reject_count),
    .pre_peak       (pre_peak),
    .ctrl_peak      (ctrl_peak),
    .post_peak      (post_peak),
    .worst_total    (worst_total),
    .worst_pre      (worst_pre),
    .worst_ctrl     (worst_ctrl),
    .worst_post     (worst_post),
    .worst_flags    (worst_flags)
  );

  // predictor state, a private copy of the recorder's statistics
  logic [CNT_W-1:0]   good_seen;
  logic [CNT_W-1:0]   bad_seen;
  logic [FIELD_W-1:0] max_pre;
  logic [FIELD_W-1:0] max_ctrl;
  logic [FIELD_W-1:0] max_post;
  logic [FIELD_W-1:0] rec_total;
  logic [FIELD_W-1:0] rec_pre;
  logic [FIELD_W-1:0] rec_ctrl;
  logic [FIELD_W-1:0] rec_post;
  logic [FLAG_W-1:0]  rec_flags;

  tick_stats_t pending_stats[$];   // stats still owed by the recorder, oldest first
  stim_row_t   opening_rows[$];
  stim_row_t   closing_rows[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  bit calm;                        // no idling on either side while set

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // clear the predictor to the reset state of the recorder
  function automatic void clear_stats();
    good_seen = '0;
    bad_seen  = '0;
    max_pre   = '0;
    max_ctrl  = '0;
    max_post  = '0;
    rec_total = '0;
    rec_pre   = '0;
    rec_ctrl  = '0;
    rec_post  = '0;
    rec_flags = '0;
  endfunction

  // update the statistics with one sample and report them
  function automatic tick_stats_t predict_tick(tick_sample_t s);
    tick_stats_t        r;
    logic [FIELD_W-1:0] rest;
    bit                 ok;
    ok = 1'b1;
    // sum check by subtraction, no borrow allowed, so wrapped sums fail
    if (s.on > 2'd1 || s.taken > s.on || s.pre > s.total) begin
      ok = 1'b0;
    end else begin
      rest = s.total - s.pre;
      if (s.ctrl > rest) begin
        ok = 1'b0;
      end else begin
        ok = (s.post == rest - s.ctrl);
      end
    end
    r.replaced = 1'b0;
    r.acc      = ok;
    if (!ok) begin
      if (bad_seen != '1) bad_seen = bad_seen + 1'b1;
    end else begin
      // the first good sample wins outright; ties on total keep the old record
      r.replaced = (good_seen == '0) || (s.total > rec_total);
      if (good_seen != '1) good_seen = good_seen + 1'b1;
      if (s.pre > max_pre) max_pre = s.pre;
      if (s.ctrl > max_ctrl) max_ctrl = s.ctrl;
      if (s.post > max_post) max_post = s.post;
      if (r.replaced) begin
        rec_total = s.total;
        rec_pre   = s.pre;
        rec_ctrl  = s.ctrl;
        rec_post  = s.post;
        rec_flags = {s.taken[0], s.on[0]};
      end
    end
    r.good_cnt = good_seen;
    r.bad_cnt  = bad_seen;
    r.pre_pk   = max_pre;
    r.ctrl_pk  = max_ctrl;
    r.post_pk  = max_post;
    r.w_total  = rec_total;
    r.w_pre    = rec_pre;
    r.w_ctrl   = rec_ctrl;
    r.w_post   = rec_post;
    r.w_flags  = rec_flags;
    return r;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic tick_sample_t mk_sample(logic [FLAG_W-1:0] on, logic [FLAG_W-1:0] taken,
                                             logic [FIELD_W-1:0] pre, logic [FIELD_W-1:0] ctrl,
                                             logic [FIELD_W-1:0] post, logic [FIELD_W-1:0] total);
    tick_sample_t s;
    s.on    = on;
    s.taken = taken;
    s.pre   = pre;
    s.ctrl  = ctrl;
    s.post  = post;
    s.total = total;
    return s;
  endfunction

  // well-formed sample: the total split over the three segments, roles rotated
  function automatic tick_sample_t split_tick(logic [FIELD_W-1:0] total);
    tick_sample_t       s;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] c;
    a = $urandom_range(total, 0);
    b = $urandom_range(total - a, 0);
    c = total - a - b;
    case ($urandom_range(2, 0))
      0: begin
        s.pre = a; s.ctrl = b; s.post = c;
      end
      1: begin
        s.pre = b; s.ctrl = c; s.post = a;
      end
      default: begin
        s.pre = c; s.ctrl = a; s.post = b;
      end
    endcase
    s.on    = FLAG_W'($urandom_range(1, 0));
    s.taken = FLAG_W'($urandom_range(s.on, 0));
    s.total = total;
    return s;
  endfunction

  // random sample: mostly well-formed, with new records and ties on the record
  function automatic tick_sample_t random_tick();
    tick_sample_t       s;
    logic [FIELD_W-1:0] total;
    int                 r;
    r = $urandom_range(99, 0);
    if (r < 40) begin
      total = $urandom_range(2000, 0);
    end else if (r < 65) begin
      total = $urandom;
    end else if (r < 85) begin
      total = (rec_total < 32'hFFFF_0000) ? rec_total + $urandom_range(5000, 1) : rec_total;
    end else begin
      total = rec_total;
    end
    s = split_tick(total);
    if ($urandom_range(99, 0) < 25) begin
      // noise and broken samples
      case ($urandom_range(4, 0))
        0: s = mk_sample(FLAG_W'($urandom_range(3, 0)), FLAG_W'($urandom_range(3, 0)),
                         $urandom, $urandom, $urandom, $urandom);
        1: s.post = $urandom_range(1, 0) ? s.post + 1'b1 : s.post - 1'b1;
        2: s.on = FLAG_W'($urandom_range(3, 2));
        3: s.taken = s.on + 1'b1;
        default: s.pre = s.total + 1'b1;
      endcase
    end
    return s;
  endfunction

  // offer one sample, hold it until the transfer, then log what it must produce
  task automatic send_tick(tick_sample_t s, bit has_stats, tick_stats_t stats);
    tick_stats_t predicted;
    in_valid    <= 1'b1;
    trace_on    <= s.on;
    trace_taken <= s.taken;
    pre_cycles  <= s.pre;
    ctrl_cycles <= s.ctrl;
    post_cycles <= s.post;
    tick_cycles <= s.total;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer happened at this edge
    predicted = predict_tick(s);
    pending_stats.push_back(has_stats ? stats : predicted);
  endtask

  // idle the input between transfers; leaves in_valid alone when no gap
  task automatic input_gap();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic walk_rows(ref stim_row_t rows[$]);
    foreach (rows[i]) begin
      send_tick(rows[i].s, rows[i].has_stats, rows[i].stats);
      input_gap();
    end
  endtask

  task automatic add_row(ref stim_row_t rows[$], input tick_sample_t s,
                         input bit has_stats = 1'b0, input tick_stats_t stats = '0);
    stim_row_t row;
    row.s         = s;
    row.has_stats = has_stats;
    row.stats     = stats;
    rows.push_back(row);
  endtask

  function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                      logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result channel monitor
  always @(posedge clk) begin : watch_results
    tick_stats_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        $error("result transfer with no sample pending");
        mismatch_count++;
      end else begin
        want = pending_stats.pop_front();
        check_field("worst_replaced", FIELD_W'(want.replaced), FIELD_W'(worst_replaced));
        check_field("accepted", FIELD_W'(want.acc), FIELD_W'(accepted));
        check_field("valid_count", want.good_cnt, valid_count);
        check_field("reject_count", want.bad_cnt, reject_count);
        check_field("pre_peak", want.pre_pk, pre_peak);
        check_field("ctrl_peak", want.ctrl_pk, ctrl_peak);
        check_field("post_peak", want.post_pk, post_peak);
        check_field("worst_total", want.w_total, worst_total);
        check_field("worst_pre", want.w_pre, worst_pre);
        check_field("worst_ctrl", want.w_ctrl, worst_ctrl);
        check_field("worst_post", want.w_post, worst_post);
        check_field("worst_flags", FIELD_W'(want.w_flags), FIELD_W'(worst_flags));
      end
    end
  end

  // receiver: stalls of random length between ready stretches
  initial begin : drive_out_ready
    int stall;
    out_ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int n;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    trace_on       <= '0;
    trace_taken    <= '0;
    pre_cycles     <= '0;
    ctrl_cycles    <= '0;
    post_cycles    <= '0;
    tick_cycles    <= '0;
    calm           = 1'b0;
    clear_stats();

    // opening table, starting right after reset
    // enable flag above one, then sampled above enabled: both rejected
    add_row(opening_rows, mk_sample(2'd2, 2'd0, 0, 0, 0, 0), 1'b1,
            {1'b0, 1'b0, 32'd0, 32'd1, {7{32'd0}}, 2'd0});
    add_row(opening_rows, mk_sample(2'd0, 2'd1, 0, 0, 0, 0), 1'b1,
            {1'b0, 1'b0, 32'd0, 32'd2, {7{32'd0}}, 2'd0});
    // first good sample takes the record even with a zero total
    add_row(opening_rows, mk_sample(2'd1, 2'd1, 0, 0, 0, 0), 1'b1,
            {1'b1, 1'b1, 32'd1, 32'd2, {7{32'd0}}, 2'd3});
    // tie with the stored total keeps the record
    add_row(opening_rows, mk_sample(2'd0, 2'd0, 0, 0, 0, 0));
    add_row(opening_rows, mk_sample(2'd3, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    add_row(opening_rows, mk_sample(2'd1, 2'd2, 1, 2, 3, 6));
    add_row(opening_rows, mk_sample(2'd3, 2'd0, 1, 2, 3, 6));
    // sum check by subtraction: pre over total, ctrl over the rest, post off by one
    add_row(opening_rows, mk_sample(2'd1, 2'd0, 10, 0, 0, 5));
    add_row(opening_rows, mk_sample(2'd1, 2'd0, 3, 5, 0, 7));
    add_row(opening_rows, mk_sample(2'd0, 2'd0, 1, 1, 1, 4));
    add_row(opening_rows, mk_sample(2'd0, 2'd0, 1, 1, 1, 2));
    // sums that wrap to the total must still be rejected
    add_row(opening_rows, mk_sample(2'd1, 2'd1, ALL_ONES, 2, 0, 1));
    add_row(opening_rows, mk_sample(2'd1, 2'd1, 1, ALL_ONES, 2, 2));
    add_row(opening_rows, mk_sample(2'd1, 2'd0, 1, 1, ALL_ONES, 1));
    add_row(opening_rows, mk_sample(2'd1, 2'd0, 100, 200, 300, 600));
    add_row(opening_rows, mk_sample(2'd0, 2'd0, 50, 500, 50, 600));
    add_row(opening_rows, mk_sample(2'd1, 2'd1, 700, 0, 0, 700));

    // closing table: maximum totals, kept for last since nothing beats them
    add_row(closing_rows, mk_sample(2'd1, 2'd1, ALL_ONES, 0, 0, ALL_ONES));
    add_row(closing_rows, mk_sample(2'd0, 2'd0, 0, ALL_ONES, 0, ALL_ONES));
    add_row(closing_rows, mk_sample(2'd1, 2'd0, 0, 0, ALL_ONES, ALL_ONES));
    add_row(closing_rows, mk_sample(2'd1, 2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 0, ALL_ONES));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    walk_rows(opening_rows);

    // random part; every fourth block runs with no idling at all
    // the saturating counters cannot reach their ceiling within this run
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) calm = ((n / BLOCK_ITEMS) % 4 == 3);
      send_tick(random_tick(), 1'b0, '0);
      input_gap();
    end
    calm = 1'b0;

    walk_rows(closing_rows);
    in_valid <= 1'b0;

    // drain, then a few quiet cycles to catch stray results
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
